@@ hdl/common_divisor_reduction_macros.svh @@
// Assertion macros for the common divisor reduction block.
// Included by the modules that check their own logic; depends on nothing.
`ifndef COMMON_DIVISOR_REDUCTION_MACROS_SVH
`define COMMON_DIVISOR_REDUCTION_MACROS_SVH

`ifndef SYNTH
`define CDR_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CDR_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons)
`define CDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/cdr_pkg.sv @@
// Shared types, constants and the microcode program of the common divisor reduction block.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package cdr_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int UPC_W = 5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SHR_AB,
		OP_SHR_A,
		OP_SHR_B,
		OP_SUB,
		OP_SHL_A,
		OP_NEXT,
		OP_SETD,
		OP_SET_ONE,
		OP_DLOAD,
		OP_DSTEP,
		OP_DSTORE,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		CND_NONE,
		CND_ALWAYS,
		CND_IDLE,
		CND_A_ZERO,
		CND_B_ZERO,
		CND_EITHER_ODD,
		CND_A_ODD,
		CND_B_ODD,
		CND_B_NZ,
		CND_PASS,
		CND_DIV_MORE,
		CND_IDX_MORE
	} cnd_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		op_t  op;
		cnd_t cnd;
		upc_t tgt;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic accept;
	} ctrl_t;

	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic a_odd;
		logic b_odd;
		logic pass;
		logic div_more;
		logic idx_more;
	} stat_t;

	localparam upc_t S_HALT     = 5'd0;
	localparam upc_t S_CHECK    = 5'd1;
	localparam upc_t S_GCD      = 5'd2;
	localparam upc_t S_TZ_TEST  = 5'd3;
	localparam upc_t S_TZ_SHIFT = 5'd4;
	localparam upc_t S_A_TEST   = 5'd5;
	localparam upc_t S_A_SHIFT  = 5'd6;
	localparam upc_t S_B_TEST   = 5'd7;
	localparam upc_t S_B_SHIFT  = 5'd8;
	localparam upc_t S_SUB      = 5'd9;
	localparam upc_t S_SUB_TEST = 5'd10;
	localparam upc_t S_GDONE    = 5'd11;
	localparam upc_t S_NEXT     = 5'd12;
	localparam upc_t S_SETD     = 5'd13;
	localparam upc_t S_ONE      = 5'd14;
	localparam upc_t S_DLOAD    = 5'd15;
	localparam upc_t S_DSTEP    = 5'd16;
	localparam upc_t S_DSTORE   = 5'd17;
	localparam upc_t S_OUT      = 5'd18;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w = '{op: OP_NOP, cnd: CND_ALWAYS, tgt: S_HALT};
		case (pc)
			S_HALT:     w = '{op: OP_NOP,     cnd: CND_IDLE,       tgt: S_HALT};
			S_CHECK:    w = '{op: OP_NOP,     cnd: CND_A_ZERO,     tgt: S_ONE};
			S_GCD:      w = '{op: OP_NOP,     cnd: CND_B_ZERO,     tgt: S_GDONE};
			S_TZ_TEST:  w = '{op: OP_NOP,     cnd: CND_EITHER_ODD, tgt: S_A_TEST};
			S_TZ_SHIFT: w = '{op: OP_SHR_AB,  cnd: CND_ALWAYS,     tgt: S_TZ_TEST};
			S_A_TEST:   w = '{op: OP_NOP,     cnd: CND_A_ODD,      tgt: S_B_TEST};
			S_A_SHIFT:  w = '{op: OP_SHR_A,   cnd: CND_ALWAYS,     tgt: S_A_TEST};
			S_B_TEST:   w = '{op: OP_NOP,     cnd: CND_B_ODD,      tgt: S_SUB};
			S_B_SHIFT:  w = '{op: OP_SHR_B,   cnd: CND_ALWAYS,     tgt: S_B_TEST};
			S_SUB:      w = '{op: OP_SUB,     cnd: CND_NONE,       tgt: S_HALT};
			S_SUB_TEST: w = '{op: OP_NOP,     cnd: CND_B_NZ,       tgt: S_B_TEST};
			S_GDONE:    w = '{op: OP_SHL_A,   cnd: CND_PASS,       tgt: S_SETD};
			S_NEXT:     w = '{op: OP_NEXT,    cnd: CND_ALWAYS,     tgt: S_GCD};
			S_SETD:     w = '{op: OP_SETD,    cnd: CND_ALWAYS,     tgt: S_DLOAD};
			S_ONE:      w = '{op: OP_SET_ONE, cnd: CND_NONE,       tgt: S_HALT};
			S_DLOAD:    w = '{op: OP_DLOAD,   cnd: CND_NONE,       tgt: S_HALT};
			S_DSTEP:    w = '{op: OP_DSTEP,   cnd: CND_DIV_MORE,   tgt: S_DSTEP};
			S_DSTORE:   w = '{op: OP_DSTORE,  cnd: CND_IDX_MORE,   tgt: S_DLOAD};
			S_OUT:      w = '{op: OP_OUT,     cnd: CND_ALWAYS,     tgt: S_HALT};
			default:    w = '{op: OP_NOP,     cnd: CND_ALWAYS,     tgt: S_HALT};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/cdr_useq.sv @@
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on cdr_pkg for the control word, the program and the status struct.
`timescale 1ns / 1ps

module cdr_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cdr_pkg::stat_t stat,
	output cdr_pkg::ctrl_t ctrl,
	output logic           busy
);

	cdr_pkg::upc_t   pc_q;
	cdr_pkg::uword_t uw;
	logic            jump;

	assign uw = cdr_pkg::ucode(pc_q);
	assign busy = (pc_q != cdr_pkg::S_HALT);
	assign ctrl.op = uw.op;
	assign ctrl.accept = start && (pc_q == cdr_pkg::S_HALT);

	always_comb begin
		case (uw.cnd)
			cdr_pkg::CND_NONE:       jump = 1'b0;
			cdr_pkg::CND_ALWAYS:     jump = 1'b1;
			cdr_pkg::CND_IDLE:       jump = !start;
			cdr_pkg::CND_A_ZERO:     jump = stat.a_zero;
			cdr_pkg::CND_B_ZERO:     jump = stat.b_zero;
			cdr_pkg::CND_EITHER_ODD: jump = stat.a_odd || stat.b_odd;
			cdr_pkg::CND_A_ODD:      jump = stat.a_odd;
			cdr_pkg::CND_B_ODD:      jump = stat.b_odd;
			cdr_pkg::CND_B_NZ:       jump = !stat.b_zero;
			cdr_pkg::CND_PASS:       jump = stat.pass;
			cdr_pkg::CND_DIV_MORE:   jump = stat.div_more;
			cdr_pkg::CND_IDX_MORE:   jump = stat.idx_more;
			default:                 jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cdr_pkg::S_HALT;
		end else if (jump) begin
			pc_q <= uw.tgt;
		end else begin
			pc_q <= pc_q + cdr_pkg::upc_t'(1);
		end
	end

endmodule

@@ hdl/cdr_datapath.sv @@
// Datapath of the common divisor reduction: binary gcd registers and a bit-serial divider.
// Depends on cdr_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "common_divisor_reduction_macros.svh"

module cdr_datapath #(
	parameter int VALUE_WIDTH = cdr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdr_pkg::ctrl_t                ctrl,
	output cdr_pkg::stat_t                stat,
	input  logic signed [VALUE_WIDTH-1:0] first_value,
	input  logic signed [VALUE_WIDTH-1:0] second_value,
	input  logic signed [VALUE_WIDTH-1:0] third_value,
	output logic signed [VALUE_WIDTH-1:0] reduced_first,
	output logic signed [VALUE_WIDTH-1:0] reduced_second,
	output logic signed [VALUE_WIDTH-1:0] reduced_third,
	output logic        [VALUE_WIDTH-2:0] common_divisor,
	output logic                          done
);

	localparam int W = VALUE_WIDTH;
	localparam int K_W = $clog2(W);
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     in_v [3];
	logic [W-1:0]     in_mag [3];
	logic [W-1:0]     m_q [3];
	logic [2:0]       neg_q;
	logic [W-1:0]     res_q [3];
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [K_W-1:0]   k_q;
	logic [W-2:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       idx_q;
	logic             pass_q;
	logic             done_q;
	logic [W-1:0]     rem_sh;
	logic [W-1:0]     div_ext;
	logic             rem_ge;
	logic             a_gt_b;
	logic [W-1:0]     quo_signed;

	assign in_v[0] = $unsigned(first_value);
	assign in_v[1] = $unsigned(second_value);
	assign in_v[2] = $unsigned(third_value);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_mag[i] = in_v[i][W-1] ? (~in_v[i] + W'(1)) : in_v[i];
		end
	end

	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign div_ext = {1'b0, d_q};
	assign rem_ge = (rem_sh >= div_ext);
	assign a_gt_b = (a_q > b_q);
	assign quo_signed = neg_q[idx_q] ? (~quo_q + W'(1)) : quo_q;

	assign stat.a_zero = (a_q == '0);
	assign stat.b_zero = (b_q == '0);
	assign stat.a_odd = a_q[0];
	assign stat.b_odd = b_q[0];
	assign stat.pass = pass_q;
	assign stat.div_more = (cnt_q != CNT_W'(1));
	assign stat.idx_more = (idx_q != 2'd2);

	assign reduced_first = $signed(res_q[0]);
	assign reduced_second = $signed(res_q[1]);
	assign reduced_third = $signed(res_q[2]);
	assign common_divisor = d_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= 2'd0;
			cnt_q <= '0;
		end else begin
			done_q <= (ctrl.op == cdr_pkg::OP_OUT);
			if (ctrl.accept) begin
				pass_q <= 1'b0;
				idx_q <= 2'd0;
			end
			case (ctrl.op)
				cdr_pkg::OP_NEXT:   pass_q <= 1'b1;
				cdr_pkg::OP_DLOAD:  cnt_q <= CNT_W'(W);
				cdr_pkg::OP_DSTEP:  cnt_q <= cnt_q - CNT_W'(1);
				cdr_pkg::OP_DSTORE: idx_q <= idx_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			for (int i = 0; i < 3; i++) begin
				m_q[i] <= in_mag[i];
				neg_q[i] <= in_v[i][W-1];
			end
			a_q <= in_mag[0];
			b_q <= in_mag[1];
			k_q <= '0;
		end
		case (ctrl.op)
			cdr_pkg::OP_SHR_AB: begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + K_W'(1);
			end
			cdr_pkg::OP_SHR_A: a_q <= a_q >> 1;
			cdr_pkg::OP_SHR_B: b_q <= b_q >> 1;
			cdr_pkg::OP_SUB: begin
				if (a_gt_b) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			cdr_pkg::OP_SHL_A: a_q <= a_q << k_q;
			cdr_pkg::OP_NEXT: begin
				b_q <= m_q[2];
				k_q <= '0;
			end
			cdr_pkg::OP_SETD: begin
				d_q <= a_q[W-1] ? {1'b1, {(W-2){1'b0}}} : a_q[W-2:0];
			end
			cdr_pkg::OP_SET_ONE: d_q <= (W-1)'(1);
			cdr_pkg::OP_DLOAD: begin
				rem_q <= '0;
				quo_q <= m_q[idx_q];
			end
			cdr_pkg::OP_DSTEP: begin
				rem_q <= rem_ge ? (rem_sh - div_ext) : rem_sh;
				quo_q <= {quo_q[W-2:0], rem_ge};
			end
			cdr_pkg::OP_DSTORE: res_q[idx_q] <= quo_signed;
			default: ;
		endcase
	end

	`CDR_ASSERT_HOLDS(a_sub_odd, clk, arst_n, ctrl.op == cdr_pkg::OP_SUB, a_q[0] && b_q[0])
	`CDR_ASSERT_HOLDS(a_done_divisor, clk, arst_n, done_q, d_q != '0)
	`CDR_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`CDR_ASSERT_HOLDS(a_next_once, clk, arst_n, ctrl.op == cdr_pkg::OP_NEXT, !pass_q)

endmodule

@@ hdl/common_divisor_reduction.sv @@
// Top level of the common divisor reduction block: sequencer plus datapath.
// Depends on cdr_pkg, cdr_useq and cdr_datapath.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; busy then stays high
// until the result is out. Each word gives exactly one result, shown for a
// single cycle with done high, and the receiver cannot stall it, so the
// result must be captured in that cycle; the result ports keep their values
// afterwards until the next word is reduced. The time from one accepted word
// to the earliest next one is set by the microcode loops of the binary gcd
// (one shift or one subtract per step, run twice, skipped when the first
// value is zero) and of the bit-serial divider that runs VALUE_WIDTH steps
// for each of the three values. The next word can be taken in the cycle in
// which done is high.

module common_divisor_reduction #(
	parameter int VALUE_WIDTH = cdr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] first_value,
	input  logic signed [VALUE_WIDTH-1:0] second_value,
	input  logic signed [VALUE_WIDTH-1:0] third_value,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] reduced_first,
	output logic signed [VALUE_WIDTH-1:0] reduced_second,
	output logic signed [VALUE_WIDTH-1:0] reduced_third,
	output logic        [VALUE_WIDTH-2:0] common_divisor
);

	cdr_pkg::ctrl_t ctrl;
	cdr_pkg::stat_t stat;

	cdr_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	cdr_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.first_value    (first_value),
		.second_value   (second_value),
		.third_value    (third_value),
		.reduced_first  (reduced_first),
		.reduced_second (reduced_second),
		.reduced_third  (reduced_third),
		.common_divisor (common_divisor),
		.done           (done)
	);

endmodule

@@ sim/common_divisor_reduction_tb.sv @@
// Testbench for common_divisor_reduction: directed rows, then random words checked against a predictor.
// Depends on cdr_pkg and the common_divisor_reduction RTL; reads no files.
`timescale 1ns / 1ps

module common_divisor_reduction_tb;

	localparam int W = cdr_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_WORDS = 1800;
	localparam int SLOWEST_WORD = 18 * W + 20;
	localparam int CYCLE_LIMIT = 12000000;

	localparam logic signed [W-1:0] VMAX = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [W-1:0] HALF = 32'sh4000_0000;
	localparam logic [W-2:0] DMAX = 31'h7fff_ffff;
	localparam logic [W-2:0] DSAT = 31'h4000_0000;

	typedef struct packed {
		logic signed [W-1:0] first;
		logic signed [W-1:0] second;
		logic signed [W-1:0] third;
	} triple_t;

	typedef struct packed {
		logic signed [W-1:0] rfirst;
		logic signed [W-1:0] rsecond;
		logic signed [W-1:0] rthird;
		logic [W-2:0]        divisor;
	} reduction_t;

	typedef struct packed {
		triple_t    operands;
		logic       typed;
		reduction_t want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 22;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 31'd1}},
		'{'{32'sd0, 32'sd6, 32'sd9}, 1'b1, '{32'sd0, 32'sd6, 32'sd9, 31'd1}},
		'{'{32'sd0, VMIN, VMAX}, 1'b1, '{32'sd0, VMIN, VMAX, 31'd1}},
		'{'{32'sd12, 32'sd0, 32'sd0}, 1'b1, '{32'sd1, 32'sd0, 32'sd0, 31'd12}},
		'{'{-32'sd12, 32'sd0, 32'sd0}, 1'b1, '{-32'sd1, 32'sd0, 32'sd0, 31'd12}},
		'{'{-32'sd1, 32'sd0, 32'sd0}, 1'b1, '{-32'sd1, 32'sd0, 32'sd0, 31'd1}},
		'{'{VMAX, 32'sd0, 32'sd0}, 1'b1, '{32'sd1, 32'sd0, 32'sd0, DMAX}},
		'{'{VMIN, 32'sd0, 32'sd0}, 1'b1, '{-32'sd2, 32'sd0, 32'sd0, DSAT}},
		'{'{VMIN, VMIN, VMIN}, 1'b1, '{-32'sd2, -32'sd2, -32'sd2, DSAT}},
		'{'{VMIN, HALF, 32'sd0}, 1'b1, '{-32'sd2, 32'sd1, 32'sd0, DSAT}},
		'{'{HALF, HALF, 32'sd0}, 1'b1, '{32'sd1, 32'sd1, 32'sd0, DSAT}},
		'{'{VMAX, VMAX, VMAX}, 1'b1, '{32'sd1, 32'sd1, 32'sd1, DMAX}},
		'{'{-32'sd1, -32'sd1, -32'sd1}, 1'b1, '{-32'sd1, -32'sd1, -32'sd1, 31'd1}},
		'{'{32'sd1, VMIN, VMAX}, 1'b1, '{32'sd1, VMIN, VMAX, 31'd1}},
		'{'{32'sd6, 32'sd9, 32'sd0}, 1'b1, '{32'sd2, 32'sd3, 32'sd0, 31'd3}},
		'{'{-32'sd6, 32'sd9, -32'sd15}, 1'b1, '{-32'sd2, 32'sd3, -32'sd5, 31'd3}},
		'{'{VMAX, VMIN, 32'sd0}, 1'b0, '0},
		'{'{VMIN, VMAX, -32'sd1}, 1'b0, '0},
		'{'{32'sd48, -32'sd180, 32'sd0}, 1'b0, '0},
		'{'{32'sd1048576, 32'sd786432, -32'sd655360}, 1'b0, '0},
		'{'{32'sd63252, 32'sd21084, -32'sd7919}, 1'b0, '0},
		'{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F}, 1'b0, '0}
	};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic signed [W-1:0] first_value = '0;
	logic signed [W-1:0] second_value = '0;
	logic signed [W-1:0] third_value = '0;
	logic                busy;
	logic                done;
	logic signed [W-1:0] reduced_first;
	logic signed [W-1:0] reduced_second;
	logic signed [W-1:0] reduced_third;
	logic [W-2:0]        common_divisor;

	reduction_t pending_reductions[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;

	common_divisor_reduction #(
		.VALUE_WIDTH(W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_value(first_value),
		.second_value(second_value),
		.third_value(third_value),
		.done(done),
		.reduced_first(reduced_first),
		.reduced_second(reduced_second),
		.reduced_third(reduced_third),
		.common_divisor(common_divisor)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [W-1:0] euclid_gcd(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] r;
		a = x;
		b = y;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic reduction_t reduce_by_gcd(input triple_t w);
		logic [W-1:0] mag [3];
		logic [W-1:0] q [3];
		logic         neg [3];
		logic [W-1:0] d;
		reduction_t   res;
		neg[0] = w.first[W-1];
		neg[1] = w.second[W-1];
		neg[2] = w.third[W-1];
		mag[0] = neg[0] ? ~w.first + 1'b1 : w.first;
		mag[1] = neg[1] ? ~w.second + 1'b1 : w.second;
		mag[2] = neg[2] ? ~w.third + 1'b1 : w.third;
		d = 1;
		if (mag[0] != 0) begin
			d = euclid_gcd(euclid_gcd(mag[0], mag[1]), mag[2]);
			// A gcd of 2^(W-1) does not fit the divisor port and saturates.
			if (d > {1'b0, DMAX})
				d = {1'b0, DSAT};
		end
		for (int i = 0; i < 3; i++) begin
			q[i] = mag[i] / d;
			if (neg[i])
				q[i] = ~q[i] + 1'b1;
		end
		res.rfirst = q[0];
		res.rsecond = q[1];
		res.rthird = q[2];
		res.divisor = d[W-2:0];
		return res;
	endfunction

	function automatic triple_t random_triple();
		logic [W-1:0] factor;
		logic [W-1:0] cap;
		logic [W-1:0] k;
		logic [W-1:0] v [3];
		int           tz;
		triple_t      w;
		factor = $urandom >> $urandom_range(0, W - 1);
		if (factor == 0)
			factor = 1;
		tz = $urandom_range(0, 8);
		if (factor <= ({1'b0, DMAX} >> tz))
			factor = factor << tz;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 15))
				0: v[i] = '0;
				1: v[i] = $urandom;
				2: begin
					case ($urandom_range(0, 3))
						0: v[i] = VMIN;
						1: v[i] = VMAX;
						2: v[i] = 1;
						default: v[i] = '1;
					endcase
				end
				default: begin
					cap = {1'b0, DMAX} / factor;
					if ($urandom_range(0, 1) == 0 && cap > 1000)
						cap = 1000;
					k = $urandom_range(0, cap);
					v[i] = factor * k;
					if ($urandom_range(0, 1) == 1)
						v[i] = ~v[i] + 1'b1;
				end
			endcase
		end
		w.first = v[0];
		w.second = v[1];
		w.third = v[2];
		return w;
	endfunction

	// Start stays high from one word to the next unless a gap is taken, so the
	// block often sees a new word waiting the moment it drops busy.
	task automatic issue_word(input triple_t w, input reduction_t want, input logic quiet);
		int hold;
		hold = 0;
		if (!quiet) begin
			while ($urandom_range(0, 99) < 24)
				hold++;
			if ($urandom_range(0, 15) == 0)
				hold += $urandom_range(0, SLOWEST_WORD);
		end
		repeat (hold) begin
			start <= 1'b0;
			first_value <= $urandom;
			second_value <= $urandom;
			third_value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		first_value <= w.first;
		second_value <= w.second;
		third_value <= w.third;
		do
			@(posedge clk);
		while (busy);
		pending_reductions = {pending_reductions, want};
	endtask

	always @(posedge clk) begin
		reduction_t want;
		if (arst_n && done) begin
			if (pending_reductions.size() == 0) begin
				$error("result with no word outstanding");
				mismatch_count++;
			end else begin
				want = pending_reductions.pop_front();
				if (reduced_first !== want.rfirst) begin
					$error("reduced_first: expected %0d, got %0d", want.rfirst, reduced_first);
					mismatch_count++;
				end
				if (reduced_second !== want.rsecond) begin
					$error("reduced_second: expected %0d, got %0d", want.rsecond,
						reduced_second);
					mismatch_count++;
				end
				if (reduced_third !== want.rthird) begin
					$error("reduced_third: expected %0d, got %0d", want.rthird, reduced_third);
					mismatch_count++;
				end
				if (common_divisor !== want.divisor) begin
					$error("common_divisor: expected %0d, got %0d", want.divisor,
						common_divisor);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		triple_t    w;
		reduction_t want;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			w = directed_rows[i].operands;
			want = directed_rows[i].typed ? directed_rows[i].want : reduce_by_gcd(w);
			issue_word(w, want, 1'b0);
		end
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			w = random_triple();
			issue_word(w, reduce_by_gcd(w), n >= 700 && n < 1000);
		end
		start <= 1'b0;
		while (pending_reductions.size() != 0)
			@(posedge clk);
		repeat (SLOWEST_WORD) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ common_divisor_reduction.f @@
+incdir+hdl
hdl/cdr_pkg.sv
hdl/cdr_useq.sv
hdl/cdr_datapath.sv
hdl/common_divisor_reduction.sv
sim/common_divisor_reduction_tb.sv
